### sv/imubar_pkg.sv
// Shared types and constants for the IMU boxcar average and remap block.
package imubar_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ALPHA_W = 16;
  localparam int AXES = 3;
  localparam logic [ALPHA_W-1:0] TEMP_ALPHA_RESET = 16'd741;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] acc_x;
    logic signed [SAMPLE_W-1:0] acc_y;
    logic signed [SAMPLE_W-1:0] acc_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic signed [SAMPLE_W-1:0] temp_raw;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] body_acc_x;
    logic signed [SAMPLE_W-1:0] body_acc_y;
    logic signed [SAMPLE_W-1:0] body_acc_z;
    logic signed [SAMPLE_W-1:0] body_gyro_x;
    logic signed [SAMPLE_W-1:0] body_gyro_y;
    logic signed [SAMPLE_W-1:0] body_gyro_z;
    logic signed [SAMPLE_W-1:0] temp_smoothed;
  } result_t;

endpackage

### sv/imu_boxcar_average_remap_unit.sv
// IMU boxcar averaging, chip-to-body remap and temperature smoothing: top level.
//
// Input channel (in_valid / in_stall / in_data) carries one IMU request: three
// accelerometer axes, three gyro axes and a raw temperature. Output channel
// (out_valid / out_stall / out_data) returns one result per request, in order.
// Each motion axis is averaged over the last HIST_DEPTH samples (running sum
// shifted right by floor(log2(HIST_DEPTH))), then remapped: body x = chip y,
// body y = chip x, body z = -chip z, all saturated to 16 bits. Temperature is
// smoothed in Q16.16 with weight temp_alpha, written through cfg_we / cfg_data
// only while the block is idle, which the user must ensure; the block does not.
// A result is registered into the output register (or the skid entry when that
// is held) as its request is accepted. Throughput: one request per cycle while
// in_stall is low; the rate is held by the running-sum update and the temperature
// multiply-add recurrence, with the oldest sample prefetched from the history RAM.
// A two-entry output (result register plus skid) lets a request be accepted
// while a result waits; in_stall rises only when both entries are full.
// Reset clears sums, ring pointer, temperature state and the per-entry valid
// bits (unwritten history reads as zero), and restores temp_alpha to 741.
// No clearing pass is needed; requests are accepted right after reset.
module imu_boxcar_average_remap_unit #(
  parameter int HIST_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  imubar_pkg::sample_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output imubar_pkg::result_t                 out_data,
  input  logic                                cfg_we,
  input  logic [imubar_pkg::ALPHA_W-1:0]      cfg_data
);

  localparam int SW = imubar_pkg::SAMPLE_W;
  localparam int NAX = imubar_pkg::AXES;
  localparam int PTR_W = $clog2(HIST_DEPTH);
  localparam int K = $clog2(HIST_DEPTH + 1) - 1;
  localparam int SUM_W = SW + PTR_W;
  localparam int MEAN_W = SUM_W + 1;
  localparam int WORD_W = 2 * NAX * SW;
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(HIST_DEPTH - 1);
  localparam logic signed [MEAN_W-1:0] SAT_HI = MEAN_W'((2 ** (SW - 1)) - 1);
  localparam logic signed [MEAN_W-1:0] SAT_LO = -SAT_HI - MEAN_W'(1);

  function automatic logic signed [SW-1:0] sat(input logic signed [MEAN_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) r = SAT_HI[SW-1:0];
    else if (v < SAT_LO) r = SAT_LO[SW-1:0];
    else r = v[SW-1:0];
    return r;
  endfunction

  // state
  logic [imubar_pkg::ALPHA_W-1:0] temp_alpha;
  logic signed [SUM_W-1:0] acc_sum [NAX];
  logic signed [SUM_W-1:0] gyro_sum [NAX];
  logic signed [SUM_W-1:0] acc_sum_next [NAX];
  logic signed [SUM_W-1:0] gyro_sum_next [NAX];
  logic [PTR_W-1:0] pos;
  logic [PTR_W-1:0] pos_inc;
  logic [PTR_W-1:0] rd_addr;
  logic [HIST_DEPTH-1:0] hist_valid;
  logic old_valid;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] new_word;
  logic signed [31:0] temp_state;
  logic signed [31:0] temp_state_next;

  // output stage
  logic skid_valid;
  imubar_pkg::result_t skid_data;
  imubar_pkg::result_t result;

  logic in_acc;
  logic out_take;

  logic signed [SW-1:0] new_acc [NAX];
  logic signed [SW-1:0] new_gyro [NAX];
  logic signed [MEAN_W-1:0] acc_mean [NAX];
  logic signed [MEAN_W-1:0] gyro_mean [NAX];

  logic [imubar_pkg::ALPHA_W:0] temp_weight;
  logic signed [SW+imubar_pkg::ALPHA_W:0] temp_p1;
  logic signed [49:0] temp_p2;
  logic signed [33:0] temp_sum;

  assign in_stall = skid_valid;
  assign in_acc = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  assign pos_inc = (pos == LAST_POS) ? '0 : pos + PTR_W'(1);
  // prefetch the slot the next request will overwrite
  assign rd_addr = in_acc ? pos_inc : pos;
  assign old_word = old_valid ? rd_word : '0;

  assign new_acc[0] = in_data.acc_x;
  assign new_acc[1] = in_data.acc_y;
  assign new_acc[2] = in_data.acc_z;
  assign new_gyro[0] = in_data.gyro_x;
  assign new_gyro[1] = in_data.gyro_y;
  assign new_gyro[2] = in_data.gyro_z;

  always_comb begin
    logic signed [SW-1:0] old_a;
    logic signed [SW-1:0] old_g;
    for (int i = 0; i < NAX; i++) begin
      old_a = old_word[i*SW +: SW];
      old_g = old_word[(NAX+i)*SW +: SW];
      new_word[i*SW +: SW] = new_acc[i];
      new_word[(NAX+i)*SW +: SW] = new_gyro[i];
      acc_sum_next[i] = acc_sum[i] + {{(SUM_W-SW){new_acc[i][SW-1]}}, new_acc[i]}
                        - {{(SUM_W-SW){old_a[SW-1]}}, old_a};
      gyro_sum_next[i] = gyro_sum[i] + {{(SUM_W-SW){new_gyro[i][SW-1]}}, new_gyro[i]}
                         - {{(SUM_W-SW){old_g[SW-1]}}, old_g};
      acc_mean[i] = $signed({acc_sum_next[i][SUM_W-1], acc_sum_next[i]}) >>> K;
      gyro_mean[i] = $signed({gyro_sum_next[i][SUM_W-1], gyro_sum_next[i]}) >>> K;
    end
  end

  // state' = alpha*x + floor((1 - alpha)*state), all in Q16.16
  assign temp_weight = (imubar_pkg::ALPHA_W+1)'(2 ** imubar_pkg::ALPHA_W)
                       - {1'b0, temp_alpha};
  assign temp_p1 = $signed({1'b0, temp_alpha}) * in_data.temp_raw;
  assign temp_p2 = $signed({1'b0, temp_weight}) * temp_state;
  assign temp_sum = {{(34-(SW+imubar_pkg::ALPHA_W+1)){temp_p1[SW+imubar_pkg::ALPHA_W]}},
                     temp_p1} + temp_p2[49:16];
  assign temp_state_next = temp_sum[31:0];

  always_comb begin
    result.body_acc_x = sat(acc_mean[1]);
    result.body_acc_y = sat(acc_mean[0]);
    result.body_acc_z = sat(-acc_mean[2]);
    result.body_gyro_x = sat(gyro_mean[1]);
    result.body_gyro_y = sat(gyro_mean[0]);
    result.body_gyro_z = sat(-gyro_mean[2]);
    result.temp_smoothed = temp_state_next[31:16];
  end

  imubar_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk  (clk),
    .we   (in_acc),
    .waddr(pos),
    .wdata(new_word),
    .raddr(rd_addr),
    .rdata(rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_alpha <= imubar_pkg::TEMP_ALPHA_RESET;
      for (int i = 0; i < NAX; i++) begin
        acc_sum[i] <= '0;
        gyro_sum[i] <= '0;
      end
      pos <= '0;
      hist_valid <= '0;
      old_valid <= 1'b0;
      temp_state <= '0;
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        temp_alpha <= cfg_data;
      end
      old_valid <= hist_valid[rd_addr];
      if (in_acc) begin
        for (int i = 0; i < NAX; i++) begin
          acc_sum[i] <= acc_sum_next[i];
          gyro_sum[i] <= gyro_sum_next[i];
        end
        hist_valid[pos] <= 1'b1;
        pos <= pos_inc;
        temp_state <= temp_state_next;
      end
      if (out_take || !out_valid) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_acc) begin
        out_data <= result;
      end
    end else if (in_acc) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_stalled_request_to_skid: assert property (@(posedge clk) disable iff (rst)
    (in_acc && out_valid && out_stall) |=> skid_valid)
    else $error("request accepted under output stall not held in skid");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (pos == $past(pos_inc)))
    else $error("ring pointer did not advance on accepted request");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> ($stable(temp_state) && $stable(pos)))
    else $error("filter state changed without an accepted request");
`endif

endmodule

### sv/imubar_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imubar_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
